### hdl/srr_pkg.sv
// Shared types and constants of the sequence reorder receiver.
package srr_pkg;

  localparam int CLIENT_W = 3;
  localparam int SEQ_W    = 16;
  localparam int CMD_W    = 8;
  localparam int LOST_W   = 16;
  localparam int KIND_W   = 2;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [LOST_W-1:0] LOST_MAX = '1;

  localparam logic REG_ACK_NACK_ENABLE = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK,
    KIND_NACK,
    KIND_DELIVER,
    KIND_DROP
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_NACK,
    ST_HOLD,
    ST_DROP,
    ST_DELIV0,
    ST_DELIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    kind_t               kind;
    logic [CLIENT_W-1:0] client;
    logic [SEQ_W-1:0]    seq;
    logic [CMD_W-1:0]    cmd;
    logic [LOST_W-1:0]   lost;
    logic                last;
  } res_t;

  typedef struct packed {
    logic push;
    logic flush;
    res_t res;
  } ostage_ctl_t;

endpackage

### hdl/srr_ifs.sv
// Valid/ready channel interfaces for packets in and results out.
interface srr_pkt_if;
  logic                          valid;
  logic                          ready;
  logic [srr_pkg::CLIENT_W-1:0]  client_id;
  logic [srr_pkg::SEQ_W-1:0]     seq;
  logic [srr_pkg::CMD_W-1:0]     command;

  modport source(output valid, output client_id, output seq, output command, input ready);
  modport sink(input valid, input client_id, input seq, input command, output ready);
endinterface

interface srr_res_if;
  logic                          valid;
  logic                          ready;
  logic [srr_pkg::KIND_W-1:0]    kind;
  logic [srr_pkg::CLIENT_W-1:0]  out_client;
  logic [srr_pkg::SEQ_W-1:0]     out_seq;
  logic [srr_pkg::CMD_W-1:0]     out_command;
  logic [srr_pkg::LOST_W-1:0]    lost_now;
  logic                          last;

  modport source(output valid, output kind, output out_client, output out_seq,
                 output out_command, output lost_now, output last, input ready);
  modport sink(input valid, input kind, input out_client, input out_seq,
               input out_command, input lost_now, input last, output ready);
endinterface

### hdl/srr_apb_regs.sv
// APB configuration register holding the ACK/NACK enable.
module srr_apb_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [srr_pkg::PADDR_W-1:0]  paddr,
  input  logic [srr_pkg::PDATA_W-1:0]  pwdata,
  output logic [srr_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output logic                         ack_nack_enable
);

  logic reg_idx;

  assign reg_idx = paddr[srr_pkg::PADDR_W-1];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_nack_enable <= 1'b1;
    end else if (psel && penable && pwrite && pready &&
                 (reg_idx == srr_pkg::REG_ACK_NACK_ENABLE)) begin
      ack_nack_enable <= pwdata[0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      srr_pkg::REG_ACK_NACK_ENABLE: begin
        prdata = {{(srr_pkg::PDATA_W-1){1'b0}}, ack_nack_enable};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

endmodule

### hdl/srr_out_stage.sv
// Pending result register and output register that mark the last result of a packet.
module srr_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  srr_pkg::ostage_ctl_t ctl,
  output logic                 room,
  srr_res_if.source            out_ch
);

  logic          pend_v;
  srr_pkg::res_t pend;
  srr_pkg::res_t pend_tail;
  logic          out_v;
  srr_pkg::res_t out_r;
  logic          can_emit;
  logic          move;

  assign can_emit = !out_v || out_ch.ready;
  assign room     = !pend_v || can_emit;
  assign move     = pend_v && can_emit && (ctl.push || ctl.flush);

  always_comb begin
    pend_tail      = pend;
    pend_tail.last = ctl.flush;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
      out_v  <= 1'b0;
    end else begin
      if (move) begin
        out_v <= 1'b1;
      end else if (out_ch.ready) begin
        out_v <= 1'b0;
      end
      if (ctl.push && room) begin
        pend_v <= 1'b1;
      end else if (ctl.flush && room) begin
        pend_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_r <= pend_tail;
    end
    if (ctl.push && room) begin
      pend <= ctl.res;
    end
  end

  assign out_ch.valid       = out_v;
  assign out_ch.kind        = out_r.kind;
  assign out_ch.out_client  = out_r.client;
  assign out_ch.out_seq     = out_r.seq;
  assign out_ch.out_command = out_r.cmd;
  assign out_ch.lost_now    = out_r.lost;
  assign out_ch.last        = out_r.last;

endmodule

### hdl/srr_engine.sv
// Sequencer with the per-client state memory and the reorder window memory.
module srr_engine #(
  parameter int CLIENTS  = 8,
  parameter int WINDOW   = 16,
  parameter int SEQ_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ack_nack_enable,
  srr_pkt_if.sink              in_ch,
  output srr_pkg::ostage_ctl_t ctl,
  input  logic                 room
);

  localparam int CIW    = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int HW     = $clog2(WINDOW);
  localparam int HDEPTH = CLIENTS * WINDOW;
  localparam int HAW    = $clog2(HDEPTH);
  localparam int SW     = SEQ_BITS;
  localparam int HDW    = srr_pkg::CMD_W + 1;

  localparam logic [SW-1:0] SEQ_MAX = '1;

  typedef struct packed {
    logic [SW-1:0]                ne;
    logic [srr_pkg::LOST_W-1:0]   lost;
    logic [HW-1:0]                head;
  } crec_t;

  function automatic logic [SW-1:0] seq_in(input logic [srr_pkg::SEQ_W-1:0] v);
    logic [SW+srr_pkg::SEQ_W-1:0] x;
    x = {{SW{1'b0}}, v};
    return x[SW-1:0];
  endfunction

  function automatic logic [srr_pkg::SEQ_W-1:0] seq_out(input logic [SW-1:0] v);
    logic [SW+srr_pkg::SEQ_W-1:0] x;
    x = {{srr_pkg::SEQ_W{1'b0}}, v};
    return x[srr_pkg::SEQ_W-1:0];
  endfunction

  function automatic logic [HW-1:0] slot_inc(input logic [HW-1:0] v);
    return (v == HW'(WINDOW - 1)) ? '0 : v + 1'b1;
  endfunction

  crec_t              cmem [CLIENTS];
  crec_t              c_rdata;
  crec_t              c_wdata;
  logic               c_re;
  logic               c_we;
  logic [CIW-1:0]     c_raddr;
  logic [CIW-1:0]     c_waddr;

  logic [HDW-1:0]     hmem [HDEPTH];
  logic [HDW-1:0]     h_rdata;
  logic [HDW-1:0]     h_wdata;
  logic               h_re;
  logic               h_we;
  logic [HAW-1:0]     h_raddr;
  logic [HAW-1:0]     h_waddr;

  srr_pkg::state_t    state;
  srr_pkg::state_t    state_next;
  logic [HAW-1:0]     clr;
  logic [HAW-1:0]     clr_next;

  logic [srr_pkg::CLIENT_W-1:0] c_reg;
  logic [CIW-1:0]               cidx_reg;
  logic [HAW-1:0]               base_reg;
  logic [SW-1:0]                s_reg;
  logic [srr_pkg::CMD_W-1:0]    cmd_reg;
  logic                         en_reg;

  logic [SW-1:0]                e_reg;
  logic [SW-1:0]                e_next;
  logic [srr_pkg::LOST_W-1:0]   lost_reg;
  logic [srr_pkg::LOST_W-1:0]   lost_next;
  logic [HW-1:0]                head_reg;
  logic [HW-1:0]                head_next;
  logic [SW-1:0]                m_reg;
  logic [SW-1:0]                m_next;
  logic [HW-1:0]                mslot_reg;
  logic [HW-1:0]                mslot_next;
  logic [HW-1:0]                hslot_reg;
  logic [HW-1:0]                hslot_next;

  logic [CIW+2:0]               cx;
  logic                         cval;
  logic [CIW-1:0]               cidx_w;
  logic                         in_fire;

  logic                         ahead;
  logic                         equal;
  logic                         beyond;
  logic [SW-1:0]                diff;
  logic [HW:0]                  hsum;
  logic [HW-1:0]                hslot_w;
  logic [srr_pkg::LOST_W-1:0]   lost_dec;
  logic [srr_pkg::LOST_W-1:0]   lost_inc;
  logic [SW-1:0]                m_inc;
  logic                         hv;
  logic                         clr_cli;

  assign cx       = {{CIW{1'b0}}, in_ch.client_id};
  assign cval     = cx < (CIW+3)'(CLIENTS);
  assign cidx_w   = cx[CIW-1:0];
  assign in_ch.ready = (state == srr_pkg::ST_IDLE);
  assign in_fire  = in_ch.valid && in_ch.ready;

  assign ahead    = s_reg > c_rdata.ne;
  assign equal    = s_reg == c_rdata.ne;
  assign diff     = s_reg - c_rdata.ne;
  assign beyond   = ahead && ({1'b0, diff} >= (SW+1)'(WINDOW));
  assign hsum     = {1'b0, c_rdata.head} + {1'b0, diff[HW-1:0]};
  assign hslot_w  = (hsum >= (HW+1)'(WINDOW)) ? HW'(hsum - (HW+1)'(WINDOW)) : hsum[HW-1:0];
  assign lost_dec = (en_reg && (c_rdata.lost != '0)) ? c_rdata.lost - 1'b1 : c_rdata.lost;
  assign lost_inc = (lost_reg == srr_pkg::LOST_MAX) ? lost_reg : lost_reg + 1'b1;
  assign m_inc    = m_reg + 1'b1;
  assign hv       = h_rdata[HDW-1];
  assign clr_cli  = {1'b0, clr} < (HAW+1)'(CLIENTS);

  always_ff @(posedge clk) begin
    if (c_we) begin
      cmem[c_waddr] <= c_wdata;
    end
    if (c_re) begin
      c_rdata <= cmem[c_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      hmem[h_waddr] <= h_wdata;
    end
    if (h_re) begin
      h_rdata <= hmem[h_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srr_pkg::ST_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      c_reg    <= in_ch.client_id;
      cidx_reg <= cidx_w;
      base_reg <= HAW'(HAW'(cidx_w) * HAW'(WINDOW));
      s_reg    <= seq_in(in_ch.seq);
      cmd_reg  <= in_ch.command;
      en_reg   <= ack_nack_enable;
    end
    e_reg     <= e_next;
    lost_reg  <= lost_next;
    head_reg  <= head_next;
    m_reg     <= m_next;
    mslot_reg <= mslot_next;
    hslot_reg <= hslot_next;
  end

  always_comb begin
    state_next = state;
    clr_next   = clr;
    e_next     = e_reg;
    lost_next  = lost_reg;
    head_next  = head_reg;
    m_next     = m_reg;
    mslot_next = mslot_reg;
    hslot_next = hslot_reg;

    ctl            = '0;
    ctl.res.kind   = srr_pkg::KIND_ACK;
    ctl.res.client = c_reg;
    ctl.res.lost   = lost_reg;

    c_re    = 1'b0;
    c_raddr = cidx_w;
    c_we    = 1'b0;
    c_waddr = cidx_reg;
    c_wdata = '{ne: e_reg, lost: lost_reg, head: head_reg};
    h_re    = 1'b0;
    h_raddr = base_reg + HAW'(mslot_reg);
    h_we    = 1'b0;
    h_waddr = base_reg + HAW'(head_reg);
    h_wdata = '0;

    unique case (state)
      srr_pkg::ST_CLEAR: begin
        h_we     = 1'b1;
        h_waddr  = clr;
        c_we     = clr_cli;
        c_waddr  = clr[CIW-1:0];
        c_wdata  = '{ne: SW'(1), lost: '0, head: HW'(1)};
        clr_next = clr + 1'b1;
        if (clr == HAW'(HDEPTH - 1)) begin
          state_next = srr_pkg::ST_IDLE;
        end
      end
      srr_pkg::ST_IDLE: begin
        if (in_fire && cval) begin
          c_re       = 1'b1;
          state_next = srr_pkg::ST_FETCH;
        end
      end
      srr_pkg::ST_FETCH: begin
        e_next       = c_rdata.ne;
        head_next    = c_rdata.head;
        lost_next    = lost_dec;
        m_next       = c_rdata.ne;
        mslot_next   = c_rdata.head;
        hslot_next   = hslot_w;
        ctl.push     = en_reg;
        ctl.res.kind = srr_pkg::KIND_ACK;
        ctl.res.seq  = seq_out(s_reg);
        ctl.res.lost = lost_dec;
        if (!en_reg || room) begin
          priority if (beyond) begin
            state_next = srr_pkg::ST_DROP;
          end else if (ahead && en_reg) begin
            h_re       = 1'b1;
            h_raddr    = base_reg + HAW'(c_rdata.head);
            state_next = srr_pkg::ST_NACK;
          end else if (ahead) begin
            state_next = srr_pkg::ST_HOLD;
          end else if (equal) begin
            state_next = srr_pkg::ST_DELIV0;
          end else begin
            state_next = srr_pkg::ST_FINISH;
          end
        end
      end
      srr_pkg::ST_NACK: begin
        ctl.push     = !hv;
        ctl.res.kind = srr_pkg::KIND_NACK;
        ctl.res.seq  = seq_out(m_reg);
        ctl.res.lost = lost_inc;
        if (hv || room) begin
          if (!hv) begin
            lost_next = lost_inc;
          end
          m_next     = m_inc;
          mslot_next = slot_inc(mslot_reg);
          if (m_inc == s_reg) begin
            state_next = srr_pkg::ST_HOLD;
          end else begin
            h_re    = 1'b1;
            h_raddr = base_reg + HAW'(slot_inc(mslot_reg));
          end
        end
      end
      srr_pkg::ST_HOLD: begin
        h_we       = 1'b1;
        h_waddr    = base_reg + HAW'(hslot_reg);
        h_wdata    = {1'b1, cmd_reg};
        state_next = srr_pkg::ST_FINISH;
      end
      srr_pkg::ST_DROP: begin
        ctl.push     = 1'b1;
        ctl.res.kind = srr_pkg::KIND_DROP;
        ctl.res.seq  = seq_out(s_reg);
        if (room) begin
          state_next = srr_pkg::ST_FINISH;
        end
      end
      srr_pkg::ST_DELIV0: begin
        ctl.push     = 1'b1;
        ctl.res.kind = srr_pkg::KIND_DELIVER;
        ctl.res.seq  = seq_out(e_reg);
        ctl.res.cmd  = cmd_reg;
        if (room) begin
          h_we = 1'b1;
          if (e_reg == SEQ_MAX) begin
            state_next = srr_pkg::ST_FINISH;
          end else begin
            e_next     = e_reg + 1'b1;
            head_next  = slot_inc(head_reg);
            h_re       = 1'b1;
            h_raddr    = base_reg + HAW'(slot_inc(head_reg));
            state_next = srr_pkg::ST_DELIV;
          end
        end
      end
      srr_pkg::ST_DELIV: begin
        ctl.push     = hv;
        ctl.res.kind = srr_pkg::KIND_DELIVER;
        ctl.res.seq  = seq_out(e_reg);
        ctl.res.cmd  = h_rdata[srr_pkg::CMD_W-1:0];
        if (!hv) begin
          state_next = srr_pkg::ST_FINISH;
        end else if (room) begin
          h_we = 1'b1;
          if (e_reg == SEQ_MAX) begin
            state_next = srr_pkg::ST_FINISH;
          end else begin
            e_next    = e_reg + 1'b1;
            head_next = slot_inc(head_reg);
            h_re      = 1'b1;
            h_raddr   = base_reg + HAW'(slot_inc(head_reg));
          end
        end
      end
      srr_pkg::ST_FINISH: begin
        c_we      = 1'b1;
        ctl.flush = 1'b1;
        if (room) begin
          state_next = srr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = srr_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(h_we && h_re && (h_waddr == h_raddr)))
    else $error("Reorder store read and written at the same entry.");

  a_fetch_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_fire && cval) |=> (state == srr_pkg::ST_FETCH))
    else $error("Accepted item did not fetch its client state.");

  a_nack_bound: assert property (@(posedge clk) disable iff (rst)
    (state == srr_pkg::ST_NACK) |-> (m_reg < s_reg))
    else $error("NACK walk ran past the held sequence number.");

  a_deliv_bound: assert property (@(posedge clk) disable iff (rst)
    (state == srr_pkg::ST_DELIV) |-> (e_reg > s_reg))
    else $error("Delivery walk fell behind the arriving sequence number.");
`endif

endmodule

### hdl/seq_reorder_ack_nack_receiver_unit.sv
// Top level of the per-client selective-repeat receiver with reorder window.
//
//   Channel  Direction  Handshake         Carries
//   in_ch    sink       valid/ready       client_id, seq, command
//   out_ch   source     valid/ready       kind, out_client, out_seq, out_command,
//                                         lost_now, last
//   APB      slave      psel/penable      ack_nack_enable at byte address 0
//
// An item passes through accept, state fetch and write back, with a drop step between for a
// packet beyond the window, a walk over each number below an ahead packet with acks on and a
// store of it, or a delivery of each in-order item and a read that ends the run.
// After reset a clearing pass over all CLIENTS*WINDOW reorder entries (128 by default) runs
// before the first item is accepted; configuration writes are taken throughout.
// When out_ch stalls, the walk holds in place until the output register frees.
module seq_reorder_ack_nack_receiver_unit #(
  parameter int CLIENTS  = 8,
  parameter int WINDOW   = 16,
  parameter int SEQ_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  srr_pkt_if.sink                      in_ch,
  srr_res_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [srr_pkg::PADDR_W-1:0]  paddr,
  input  logic [srr_pkg::PDATA_W-1:0]  pwdata,
  output logic [srr_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  logic                 ack_nack_enable;
  srr_pkg::ostage_ctl_t ctl;
  logic                 room;

  srr_apb_regs u_regs (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .ack_nack_enable (ack_nack_enable)
  );

  srr_engine #(
    .CLIENTS  (CLIENTS),
    .WINDOW   (WINDOW),
    .SEQ_BITS (SEQ_BITS)
  ) u_engine (
    .clk             (clk),
    .rst             (rst),
    .ack_nack_enable (ack_nack_enable),
    .in_ch           (in_ch),
    .ctl             (ctl),
    .room            (room)
  );

  srr_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule
